// File: hw/rtl/rspat_pkg.sv
`timescale 1ns / 1ps

package rspat_pkg;

   localparam int SUM_WIDTH   = 32;
   localparam int COUNT_WIDTH = 11;
   localparam int INDEX_WIDTH = 10;

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 11'd1024;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_SUM    = 1'b1;

   typedef logic [SUM_WIDTH-1:0] sum_type;

endpackage

// File: hw/rtl/range_sum_point_assign_tree.sv
`timescale 1ns / 1ps

// Range-sum tree over up to MAX_ELEMENTS signed 32-bit elements, kept heap-wise in one
// single-port-read, single-port-write RAM of 2*MAX_ELEMENTS words. An assign request
// inside the live count writes its leaf and then walks to the root, one read of the
// sibling and one write of the parent per level, with no response; others are dropped.
// A sum request walks the bounds upward, one RAM read or one level shift per cycle,
// then loads the response register once no earlier response is held by rsp_stall;
// the next request is taken while that response waits. One request is worked on at a
// time, paced by the single RAM read port. After reset a clearing pass writes zeros to
// all 2*MAX_ELEMENTS words before the first request is taken; csr writes are taken at
// any time.
module range_sum_point_assign_tree #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [rspat_pkg::INDEX_WIDTH-1:0]   req_position,
   input  logic signed [rspat_pkg::SUM_WIDTH-1:0] req_new_value,
   input  logic [rspat_pkg::INDEX_WIDTH-1:0]   req_range_left,
   input  logic [rspat_pkg::INDEX_WIDTH-1:0]   req_range_right,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rspat_pkg::SUM_WIDTH-1:0] rsp_range_total,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rspat_pkg::COUNT_WIDTH-1:0]   csr_element_count
);

   localparam int NW = $clog2(2 * MAX_ELEMENTS);
   localparam int HW = NW + 1;
   localparam int MW = $clog2(MAX_ELEMENTS + 1);
   localparam int CW = (rspat_pkg::COUNT_WIDTH > MW) ? rspat_pkg::COUNT_WIDTH : MW;

   localparam logic [CW-1:0] MAX_C      = CW'(MAX_ELEMENTS);
   localparam logic [NW-1:0] MAX_N      = NW'(MAX_ELEMENTS);
   localparam logic [HW-1:0] MAX_H      = HW'(MAX_ELEMENTS);
   localparam logic [NW-1:0] LAST_NODE  = NW'(2 * MAX_ELEMENTS - 1);
   localparam logic [NW-1:0] ROOT_NODE  = NW'(1);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_UPD_RD  = 3'd2;
   localparam logic [2:0] S_UPD_ADD = 3'd3;
   localparam logic [2:0] S_SUM     = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [NW-1:0]                   clr_ff, clr_in;
   logic [NW-1:0]                   node_ff, node_in;
   rspat_pkg::sum_type              cur_ff, cur_in;
   logic [HW-1:0]                   lo_ff, lo_in;
   logic [HW-1:0]                   hi_ff, hi_in;
   rspat_pkg::sum_type              acc_ff, acc_in;
   logic                            pend_ff, pend_in;
   logic [rspat_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rspat_pkg::sum_type              rsp_total_ff, rsp_total_in;

   logic                            wr_en;
   logic [NW-1:0]                   wr_addr;
   rspat_pkg::sum_type              wr_data;
   logic                            rd_en;
   logic [NW-1:0]                   rd_addr;
   rspat_pkg::sum_type              rd_data;

   logic [CW-1:0]                   count_ext;
   logic [CW-1:0]                   live;
   logic [CW-1:0]                   left_ext;
   logic [CW-1:0]                   right_ext;
   logic [CW-1:0]                   right_clip;
   logic                            pos_ok;
   logic                            sum_ok;
   logic                            req_accept;
   logic                            rsp_free;
   logic [NW-1:0]                   parent;
   logic [HW-1:0]                   hi_dec;

   rspat_ram #(
      .WIDTH (rspat_pkg::SUM_WIDTH),
      .DEPTH (2 * MAX_ELEMENTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign req_accept      = req_valid & ~req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_total = rsp_total_ff;
   assign csr_ready       = 1'b1;
   assign rsp_free        = ~rsp_valid_ff | ~rsp_stall;

   assign count_ext  = CW'(count_ff);
   assign live       = (count_ext > MAX_C) ? MAX_C : count_ext;
   assign left_ext   = CW'(req_range_left);
   assign right_ext  = CW'(req_range_right);
   assign right_clip = (right_ext > live - CW'(1)) ? live - CW'(1) : right_ext;
   assign pos_ok     = CW'(req_position) < live;
   assign sum_ok     = (live != '0) && (left_ext < live) && (left_ext <= right_clip);
   assign parent     = {1'b0, node_ff[NW-1:1]};
   assign hi_dec     = hi_ff - HW'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_total_in = rsp_total_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff ^ NW'(1);

      if (csr_valid && csr_ready) begin
         count_in = csr_element_count;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               if (req_operation == rspat_pkg::OP_ASSIGN) begin
                  if (pos_ok) begin
                     wr_en    = 1'b1;
                     wr_addr  = MAX_N + NW'(req_position);
                     wr_data  = req_new_value;
                     node_in  = MAX_N + NW'(req_position);
                     cur_in   = req_new_value;
                     state_in = S_UPD_RD;
                  end
               end else begin
                  acc_in   = '0;
                  pend_in  = 1'b0;
                  state_in = S_SUM;
                  if (sum_ok) begin
                     lo_in = MAX_H + HW'(left_ext);
                     hi_in = MAX_H + HW'(right_clip) + HW'(1);
                  end else begin
                     lo_in = '0;
                     hi_in = '0;
                  end
               end
            end
         end
         S_UPD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = node_ff ^ NW'(1);
            state_in = S_UPD_ADD;
         end
         S_UPD_ADD: begin
            wr_en    = 1'b1;
            wr_addr  = parent;
            wr_data  = cur_ff + rd_data;
            cur_in   = cur_ff + rd_data;
            node_in  = parent;
            state_in = (parent == ROOT_NODE) ? S_IDLE : S_UPD_RD;
         end
         S_SUM: begin
            acc_in  = pend_ff ? acc_ff + rd_data : acc_ff;
            pend_in = 1'b0;
            priority if (lo_ff >= hi_ff) begin
               if (!pend_ff && rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_total_in = acc_ff;
                  state_in     = S_IDLE;
               end
            end else if (lo_ff[0]) begin
               rd_en   = 1'b1;
               rd_addr = lo_ff[NW-1:0];
               lo_in   = lo_ff + HW'(1);
               pend_in = 1'b1;
            end else if (hi_ff[0]) begin
               rd_en   = 1'b1;
               rd_addr = hi_dec[NW-1:0];
               hi_in   = hi_dec;
               pend_in = 1'b1;
            end else begin
               lo_in = {1'b0, lo_ff[HW-1:1]};
               hi_in = {1'b0, hi_ff[HW-1:1]};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= rspat_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      cur_ff       <= cur_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      acc_ff       <= acc_in;
      rsp_total_ff <= rsp_total_in;
   end

endmodule

// File: hw/rtl/rspat_ram.sv
`timescale 1ns / 1ps

module rspat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/range_sum_point_assign_tree_checker.sv
`timescale 1ns / 1ps

module range_sum_point_assign_tree_checker #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_operation,
   input  logic [rspat_pkg::INDEX_WIDTH-1:0]   req_position,
   input  logic [rspat_pkg::SUM_WIDTH-1:0]     req_new_value,
   input  logic [rspat_pkg::INDEX_WIDTH-1:0]   req_range_left,
   input  logic [rspat_pkg::INDEX_WIDTH-1:0]   req_range_right,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [rspat_pkg::SUM_WIDTH-1:0]     rsp_range_total,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rspat_pkg::COUNT_WIDTH-1:0]   csr_element_count,
   output int                                  error_count,
   output int                                  outstanding
);

   rspat_pkg::sum_type                element_store [0:MAX_ELEMENTS-1];
   logic [rspat_pkg::COUNT_WIDTH-1:0] element_count;
   rspat_pkg::sum_type                expected_totals [$];

   function automatic int unsigned live_elements();
      return (element_count > MAX_ELEMENTS) ? MAX_ELEMENTS : element_count;
   endfunction

   // sum of the span clipped to the live elements, wrapping at 32 bits
   function automatic rspat_pkg::sum_type clipped_span_total(int unsigned first,
                                                             int unsigned last,
                                                             int unsigned live);
      rspat_pkg::sum_type total;
      int unsigned        stop;
      total = '0;
      if (first < live) begin
         stop = (last > live - 1) ? live - 1 : last;
         for (int unsigned i = first; i <= stop; i++) begin
            total += element_store[i];
         end
      end
      return total;
   endfunction

   always @(posedge clock) begin
      rspat_pkg::sum_type wanted;
      if (reset) begin
         foreach (element_store[i]) element_store[i] = '0;
         element_count = rspat_pkg::COUNT_RESET;
         expected_totals.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_totals.size() == 0) begin
               $display("%0t: range_total expected none actual %h", $time, rsp_range_total);
               error_count++;
            end else begin
               wanted = expected_totals.pop_front();
               if (rsp_range_total !== wanted) begin
                  $display("%0t: range_total expected %h actual %h",
                           $time, wanted, rsp_range_total);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_operation == rspat_pkg::OP_ASSIGN) begin
               if (req_position < live_elements())
                  element_store[req_position] = req_new_value;
            end else begin
               expected_totals = {expected_totals,
                                  clipped_span_total(req_range_left, req_range_right,
                                                     live_elements())};
            end
         end
         if (csr_valid && csr_ready)
            element_count = csr_element_count;
      end
      outstanding = expected_totals.size();
   end

endmodule

// File: dv/range_sum_point_assign_tree_tb.sv
`timescale 1ns / 1ps

module range_sum_point_assign_tree_tb;

   localparam int CLOCK_PERIOD = 12;
   localparam int MAX_ELEMENTS = 1024;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 140;

   typedef logic [rspat_pkg::INDEX_WIDTH-1:0] index_type;
   typedef logic [rspat_pkg::COUNT_WIDTH-1:0] count_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_operation;
   index_type              req_position;
   rspat_pkg::sum_type     req_new_value;
   index_type              req_range_left;
   index_type              req_range_right;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rspat_pkg::sum_type     rsp_range_total;
   logic                   csr_valid;
   logic                   csr_ready;
   count_type              csr_element_count;
   int                     error_count;
   int                     outstanding;

   bit calm = 1'b0;
   bit long_hold = 1'b0;

   range_sum_point_assign_tree #(.MAX_ELEMENTS(MAX_ELEMENTS)) dut (.*);

   range_sum_point_assign_tree_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) checker_i (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      #(CLOCK_PERIOD * 1_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin : rsp_drive
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_request(input logic op, input index_type pos,
                               input rspat_pkg::sum_type value,
                               input index_type left,
                               input index_type right);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_position    <= pos;
      req_new_value   <= value;
      req_range_left  <= left;
      req_range_right <= right;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic assign_element(input int pos, input rspat_pkg::sum_type value);
      send_request(rspat_pkg::OP_ASSIGN, index_type'(pos), value,
                   index_type'($urandom), index_type'($urandom));
   endtask

   task automatic sum_span(input int left, input int right);
      send_request(rspat_pkg::OP_SUM, index_type'($urandom), $urandom,
                   index_type'(left), index_type'(right));
   endtask

   // drain all expected totals plus any trailing assign walk
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(input count_type count);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_element_count <= count;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_index(input int live);
      if (live > 0 && $urandom_range(0, 7) != 0)
         return $urandom_range(0, live - 1);
      return $urandom_range(0, MAX_ELEMENTS - 1);
   endfunction

   function automatic rspat_pkg::sum_type pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic count_type pick_count();
      case ($urandom_range(0, 7))
         0: return count_type'(1);
         1: return count_type'(2);
         2: return count_type'(1023);
         3: return count_type'(1024);
         4: return count_type'(2047);
         5: return count_type'($urandom_range(1025, 2047));
         6: return count_type'($urandom_range(3, 64));
         default: return count_type'($urandom_range(1, 1024));
      endcase
   endfunction

   task automatic random_request(input int live);
      int left;
      if ($urandom_range(0, 9) == 0) begin
         send_request(1'($urandom), index_type'($urandom), $urandom,
                      index_type'($urandom), index_type'($urandom));
      end else if ($urandom_range(0, 1) == 0) begin
         assign_element(pick_index(live), pick_value());
      end else begin
         left = pick_index(live);
         if (left < live && $urandom_range(0, 4) != 0)
            sum_span(left, $urandom_range(left, live - 1));
         else
            sum_span(left, $urandom_range(0, MAX_ELEMENTS - 1));
      end
   endtask

   initial begin : stimulus
      count_type count;
      int        live;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = rspat_pkg::OP_ASSIGN;
      req_position      = '0;
      req_new_value     = '0;
      req_range_left    = '0;
      req_range_right   = '0;
      csr_valid         = 1'b0;
      csr_element_count = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // field extremes at full size
      write_count(rspat_pkg::COUNT_RESET);
      assign_element(0, 32'h7fff_ffff);
      assign_element(1023, 32'h8000_0000);
      assign_element(512, 32'hffff_ffff);
      sum_span(0, 1023);
      sum_span(1023, 1023);
      sum_span(0, 0);
      sum_span(600, 5);
      sum_span(1, 1022);
      wait_idle();

      // count above capacity
      write_count(count_type'(2047));
      sum_span(0, 1023);
      assign_element(1023, 32'h0000_0001);
      sum_span(1000, 1023);
      wait_idle();

      // no live elements
      write_count(count_type'(0));
      assign_element(0, 32'h0000_0005);
      sum_span(0, 1023);
      sum_span(0, 0);
      wait_idle();

      // single element, assign beyond count, span clipped, left past count
      write_count(count_type'(1));
      assign_element(0, 32'h1234_5678);
      assign_element(1, 32'h0000_0009);
      sum_span(0, 1023);
      sum_span(1, 1);
      wait_idle();

      // shrink then grow back over stored elements
      write_count(count_type'(100));
      sum_span(0, 1023);
      sum_span(50, 1023);
      wait_idle();
      write_count(count_type'(1024));
      sum_span(0, 1023);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         count = pick_count();
         live = (count > MAX_ELEMENTS) ? MAX_ELEMENTS : count;
         write_count(count);
         if (phase == PHASES - 1)
            calm = 1'b1;
         if (phase == 2) begin
            calm = 1'b1;
            long_hold = 1'b1;
            for (int i = 0; i < 24; i++) sum_span(pick_index(live), MAX_ELEMENTS - 1);
            calm = 1'b0;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) random_request(live);
         wait_idle();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/rspat_pkg.sv
hw/rtl/rspat_ram.sv
hw/rtl/range_sum_point_assign_tree.sv
dv/range_sum_point_assign_tree_checker.sv
dv/range_sum_point_assign_tree_tb.sv
